@@ design/mwr_pkg.sv @@
// ----------------------------------------------------------------------------
// mwr_pkg: shared constants for the moving-window RMS core
// Widths and defaults used by the core and its iterative arithmetic units.
// ----------------------------------------------------------------------------
package mwr_pkg;

    // half-window register
    localparam int HW_W     = 5;
    localparam int HW_RESET = 2;

    // window length 2*half_window+1 never exceeds 63
    localparam int LEN_W = HW_W + 1;

    // default parameter values
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

endpackage

@@ design/moving_window_rms_core.sv @@
// ----------------------------------------------------------------------------
// moving_window_rms_core: sliding-window RMS of a sample stream
//
// Input stream s_axis: tdata carries one signed sample, tuser marks the first
// sample of a new signal (clears the window fill), tlast the final sample.
// Output stream m_axis: tdata carries floor(sqrt(floor(sum of squares / L)))
// over the last L = 2*half_window+1 samples (capped at MAX_WINDOW); tlast
// repeats the tlast of the sample that produced it.
// A sample that leaves the window short of L samples gives no result; the
// block is ready again in the next cycle.
// Otherwise the block walks the stored window one entry per cycle, then runs
// a bit-serial divider and a bit-serial square root. s_axis_tready rises in
// the same cycle as the result becomes valid, so no new sample is taken while
// a window is in work. The output is a register: a new sample is taken while
// the last result waits, and a finished result waits in the core until the
// receiver frees it.
// half_window is written through i_cfg_we/i_cfg_wdata; the user must write
// it only while idle, as the block itself does not enforce this.
// Reset (synchronous, active low) clears fill count, write slot, state and
// output valid, and sets half_window to 2. Store contents are not cleared.
// ----------------------------------------------------------------------------
module moving_window_rms_core #(
    parameter int MAX_WINDOW  = mwr_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = mwr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [mwr_pkg::HW_W-1:0]              i_cfg_wdata,  // half_window
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata, // sample
    input  logic                                  s_axis_tuser, // start_req
    input  logic                                  s_axis_tlast, // last_input
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata, // rms_value
    output logic                                  m_axis_tlast  // last_result
);
    import mwr_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AW      = $clog2(MAX_WINDOW);
    localparam int FW      = $clog2(MAX_WINDOW + 1);
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W   = 2 * SAMPLE_BITS + LEN_W - 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]              r_state;
    logic [HW_W-1:0]         r_half;
    logic [AW-1:0]           r_slot;
    logic [FW-1:0]           r_fill;
    logic [LEN_W-1:0]        r_len;
    logic                    r_last;

    logic [SAMPLE_BITS-1:0]  r_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]  r_rd_data;
    logic [AW-1:0]           r_rd_ptr;
    logic [LEN_W-1:0]        r_left;
    logic                    r_rd_vld;
    logic                    r_sq_vld;
    logic [SQ_W-1:0]         r_sq;
    logic [SUM_W-1:0]        r_sum;

    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_out_rms;
    logic                    r_out_last;

    logic                    w_accept;
    logic [LEN_W-1:0]        w_raw_len;
    logic [LEN_W-1:0]        w_len;
    logic [FW-1:0]           n_fill_base;
    logic [FW-1:0]           n_fill;
    logic [AW-1:0]           n_slot;
    logic [2*SAMPLE_BITS-1:0] w_prod;
    logic                    w_sum_done;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [SUM_W-1:0]        w_quot;
    logic                    w_sqrt_done;
    logic [SAMPLE_BITS-1:0]  w_root;
    logic                    w_out_free;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // window length, capped at the store depth
    always_comb begin
        w_raw_len = {r_half, 1'b1};
        if (int'(w_raw_len) > MAX_WINDOW) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = w_raw_len;
        end
    end

    // fill count and write slot for the arriving sample
    always_comb begin
        n_fill_base = s_axis_tuser ? '0 : r_fill;
        if (n_fill_base != FW'(MAX_WINDOW)) begin
            n_fill = n_fill_base + 1'b1;
        end else begin
            n_fill = n_fill_base;
        end
        if (r_slot == AW'(MAX_WINDOW - 1)) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + 1'b1;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HW_W'(HW_RESET);
        end else if (i_cfg_we) begin
            r_half <= i_cfg_wdata;
        end
    end

    // sample store: written on transfer, read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_slot] <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    // square of the stored sample
    assign w_prod = $signed(r_rd_data) * $signed(r_rd_data);

    assign w_sum_done  = (r_left == '0) && !r_rd_vld && !r_sq_vld;
    assign w_div_start = (r_state == S_SUM) && w_sum_done;

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_rd_vld    <= 1'b0;
            r_sq_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output valid: set by a finished result, cleared by a transfer
            if (r_state == S_HOLD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_slot <= n_slot;
                        r_fill <= n_fill;
                        if (int'(n_fill) >= int'(w_len)) begin
                            r_state <= S_SUM;
                            r_left  <= w_len;
                        end
                    end
                end
                S_SUM: begin
                    r_rd_vld <= (r_left != '0);
                    r_sq_vld <= r_rd_vld;
                    if (r_left != '0) begin
                        r_left <= r_left - 1'b1;
                    end
                    if (w_sum_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // window walk datapath: read pointer runs backward from the newest sample
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_ptr <= r_slot;
            r_len    <= w_len;
            r_last   <= s_axis_tlast;
            r_sum    <= '0;
        end else if (r_state == S_SUM) begin
            if (r_left != '0) begin
                if (r_rd_ptr == '0) begin
                    r_rd_ptr <= AW'(MAX_WINDOW - 1);
                end else begin
                    r_rd_ptr <= r_rd_ptr - 1'b1;
                end
            end
            r_sq <= w_prod[SQ_W-1:0];
            if (r_sq_vld) begin
                r_sum <= r_sum + SUM_W'(r_sq);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_HOLD && w_out_free) begin
            r_out_rms  <= w_root;
            r_out_last <= r_last;
        end
    end

    // mean: sum divided by the window length
    mwr_div #(
        .SUM_W      (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_len),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // root of the mean; the quotient never exceeds the largest square
    mwr_sqrt #(
        .ROOT_W     (SAMPLE_BITS)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_done),
        .i_value    (w_quot[2*SAMPLE_BITS-1:0]),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_rms);
    assign m_axis_tlast  = r_out_last;

endmodule

@@ design/mwr_div.sv @@
// ----------------------------------------------------------------------------
// mwr_div: bit-serial restoring divider
// Divides a wide unsigned sum by a short window length, one quotient bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mwr_div #(
    parameter int SUM_W = 37
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [SUM_W-1:0]           i_dividend,
    input  logic [mwr_pkg::LEN_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [SUM_W-1:0]           o_quot
);
    import mwr_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] r_work;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_divisor;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [LEN_W:0]   n_trial;
    logic [LEN_W:0]   n_diff;
    logic             n_qbit;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        n_trial = {r_rem, r_work[SUM_W-1]};
        n_diff  = n_trial - {1'b0, r_divisor};
        n_qbit  = (n_trial >= {1'b0, r_divisor});
    end

    // control; done pulses once after the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: dividend shifts out, quotient shifts in behind it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[SUM_W-2:0], n_qbit};
            r_rem  <= n_qbit ? n_diff[LEN_W-1:0] : n_trial[LEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;

endmodule

@@ design/mwr_sqrt.sv @@
// ----------------------------------------------------------------------------
// mwr_sqrt: digit-by-digit integer square root
// Produces floor(sqrt(x)) one root bit per cycle, taking two radicand bits
// per step from the top.
// ----------------------------------------------------------------------------
module mwr_sqrt #(
    parameter int ROOT_W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*ROOT_W-1:0]   i_value,
    output logic                  o_done,
    output logic [ROOT_W-1:0]     o_root
);
    import mwr_pkg::*;

    localparam int IN_W  = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [IN_W-1:0]   r_val;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+2:0] n_trial_rem;
    logic [ROOT_W+2:0] n_trial;
    logic [ROOT_W+2:0] n_diff;
    logic              n_bit;

    // one step: compare remainder against 4*root+1
    always_comb begin
        n_trial_rem = {r_rem, r_val[IN_W-1:IN_W-2]};
        n_trial     = {1'b0, r_root, 2'b01};
        n_diff      = n_trial_rem - n_trial;
        n_bit       = (n_trial_rem >= n_trial);
    end

    // control; done pulses once after the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath; the root holds once finished
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[IN_W-3:0], 2'b00};
            r_rem  <= n_bit ? n_diff[ROOT_W:0] : n_trial_rem[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
